[hdl/bspm_pkg.sv]
// Shared types and mode codes for the backing store page map.
`default_nettype none
package bspm_pkg;
   localparam logic [2:0] MODE_ALLOC  = 3'd0;
   localparam logic [2:0] MODE_OPEN   = 3'd1;
   localparam logic [2:0] MODE_MAP    = 3'd2;
   localparam logic [2:0] MODE_LOOKUP = 3'd3;
   localparam logic [2:0] MODE_UNMAP  = 3'd4;
   localparam logic [2:0] MODE_FREE   = 3'd5;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // capture request word
      logic clr_step;    // clear sweep cursor, walk store slots from 0
      logic step;        // advance cursor
      logic scan;        // cursor spans all stores: start at store 0, wrap into next store
      logic wr_valid;    // write current slot valid/owner/page
      logic wr_bit;      // valid value written
      logic wr_hit;      // write goes to the slot just read instead of the cursor
      logic set_mapped;
      logic set_size;
      logic clr_store;   // clear mapped and size of selected store
      logic rsp_load;
      logic rsp_err;
      logic rsp_hit;     // report found slot
      logic rsp_alloc;   // report allocated store
   } ctl_type;

   typedef struct packed {
      logic       clear_done;
      logic       sid_ok;
      logic       alloc_ok;
      logic       mem_hit;   // registered read of current slot matches
      logic       mem_vld;   // registered read valid bit
      logic       run_end;   // cursor reached store size
      logic       fit_ok;    // run + count fits
      logic       map_done;  // mapped count reached
      logic       scan_end;  // lookup cursor at last slot
      logic       store_end; // cursor at last slot of store (free)
   } sts_type;
endpackage
`default_nettype wire

[hdl/bspm_datapath.sv]
// Datapath: store table, slot memory, cursors and result register.
`default_nettype none
module bspm_datapath
   import bspm_pkg::*;
#(
   parameter int NUM_STORES = 8,
   parameter int PAGES_PER_STORE = 256,
   parameter int PID_BITS = 6,
   parameter int VPAGE_BITS = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctl_type     ctl,
   output sts_type          sts,
   output logic             hit_mapped,
   input  wire logic [5:0]  req_process_id,
   input  wire logic [19:0] req_virtual_page,
   input  wire logic [2:0]  req_store_id,
   input  wire logic [8:0]  req_page_count,
   output logic             rsp_status,
   output logic [2:0]       rsp_store_index,
   output logic [7:0]       rsp_page_index
);
   localparam int SB = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;
   localparam int PB = (PAGES_PER_STORE > 1) ? $clog2(PAGES_PER_STORE) : 1;
   localparam int SLOTS = NUM_STORES * PAGES_PER_STORE;
   localparam int AB = SB + PB;
   localparam int CB = $clog2(PAGES_PER_STORE + 1);
   localparam int EB = PID_BITS + VPAGE_BITS + 1;

   logic [EB-1:0] mem [SLOTS];
   logic [EB-1:0] rd_ff;
   logic [NUM_STORES-1:0] mapped_ff;
   logic [CB-1:0] size_ff [NUM_STORES];

   logic [PID_BITS-1:0]   pid_ff;
   logic [VPAGE_BITS-1:0] vp_ff, vp_in;
   logic [2:0]            sid_ff;
   logic [8:0]            cnt_ff;
   logic [SB-1:0]         st_ff, st_in;   // store cursor
   logic [PB:0]           pg_ff, pg_in;   // slot cursor
   logic [8:0]            done_ff, done_in;
   logic [AB:0]           clr_ff;
   logic [SB-1:0]         alloc_idx;
   logic                  alloc_ok;
   logic [SB-1:0]         sel;
   logic [AB-1:0]         addr, rd_addr_q, wr_addr;
   logic [CB-1:0]         cur_size;
   logic                  wr_en;
   logic [EB-1:0]         wr_data;

   assign sel = sid_ff[SB-1:0];
   assign cur_size = size_ff[sel];
   assign sts.sid_ok = (32'(sid_ff) < NUM_STORES);

   always_comb begin
      alloc_ok = 1'b0;
      alloc_idx = '0;
      for (int i = NUM_STORES - 1; i >= 0; i--) begin
         if (!mapped_ff[i]) begin
            alloc_ok = 1'b1;
            alloc_idx = SB'(i);
         end
      end
   end
   assign sts.alloc_ok = alloc_ok;

   assign addr = {st_ff, pg_ff[PB-1:0]};

   // clearing pass after reset
   assign sts.clear_done = clr_ff[AB];
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (!clr_ff[AB]) clr_ff <= clr_ff + 1'b1;
   end

   // unmap clears the slot whose read produced the hit
   assign wr_addr = !clr_ff[AB] ? clr_ff[AB-1:0]
                  : (ctl.wr_hit ? rd_addr_q : addr);
   assign wr_en = !clr_ff[AB] || ctl.wr_valid;
   assign wr_data = !clr_ff[AB] ? '0
                  : {ctl.wr_bit, pid_ff, vp_in};
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[addr];
      rd_addr_q <= addr;
   end
   assign sts.mem_vld = rd_ff[EB-1];
   assign sts.mem_hit = rd_ff[EB-1] && (rd_ff[EB-2:VPAGE_BITS] == pid_ff)
                        && (rd_ff[VPAGE_BITS-1:0] == vp_ff);

   // write page is vp + done for map
   assign vp_in = vp_ff + VPAGE_BITS'(done_ff);

   assign sts.run_end = ({1'b0, pg_ff} >= (PB+2)'(cur_size));
   assign sts.fit_ok = (32'(pg_ff) + 32'(cnt_ff)) <= 32'(cur_size);
   assign sts.map_done = (done_ff == cnt_ff);
   assign sts.store_end = (32'(pg_ff) == PAGES_PER_STORE - 1);
   assign sts.scan_end = sts.store_end && (32'(st_ff) == NUM_STORES - 1);

   always_comb begin
      st_in = st_ff;
      pg_in = pg_ff;
      done_in = done_ff;
      if (ctl.clr_step) begin
         st_in = ctl.scan ? '0 : sel;
         pg_in = '0;
         done_in = '0;
      end else if (ctl.step) begin
         if (ctl.wr_valid && ctl.wr_bit) done_in = done_ff + 1'b1;
         if (ctl.scan && 32'(pg_ff) == PAGES_PER_STORE - 1) begin
            pg_in = '0;
            st_in = st_ff + 1'b1;
         end else begin
            pg_in = pg_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pid_ff <= req_process_id[PID_BITS-1:0];
         vp_ff <= VPAGE_BITS'(req_virtual_page);
         sid_ff <= req_store_id;
         cnt_ff <= req_page_count;
      end
      st_ff <= st_in;
      pg_ff <= pg_in;
      done_ff <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mapped_ff <= '0;
         for (int i = 0; i < NUM_STORES; i++) size_ff[i] <= '0;
      end else begin
         if (ctl.set_mapped) mapped_ff[sel] <= 1'b1;
         if (ctl.set_size)
            size_ff[sel] <= (32'(cnt_ff) > PAGES_PER_STORE) ?
                            CB'(PAGES_PER_STORE) : CB'(cnt_ff);
         if (ctl.clr_store) begin
            mapped_ff[sel] <= 1'b0;
            size_ff[sel] <= '0;
         end
      end
   end

   // lookup skips unmapped stores via the hit qualifier
   assign hit_mapped = mapped_ff[rd_addr_q[AB-1:PB]];

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_status <= ctl.rsp_err;
         rsp_store_index <= '0;
         rsp_page_index <= '0;
         if (ctl.rsp_alloc) rsp_store_index <= 3'(alloc_idx);
         if (ctl.rsp_hit) begin
            rsp_store_index <= 3'(rd_addr_q[AB-1:PB]);
            rsp_page_index <= 8'(rd_addr_q[PB-1:0]);
         end
      end
   end
endmodule
`default_nettype wire

[hdl/bspm_control.sv]
// Controller state machine sequencing each request word.
`default_nettype none
module bspm_control
   import bspm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_mode,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic       hit_mapped,
   input  wire sts_type    sts,
   output ctl_type         ctl
);
   localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_RUNRD = 4'd2,
                          S_RUNCK = 4'd3, S_MAPWR = 4'd4, S_SCRD = 4'd5,
                          S_SCCK = 4'd6, S_FREE = 4'd7, S_RSP = 4'd8;
   logic [3:0] state_ff, state_in;
   logic [2:0] mode_ff;
   logic       last_ff, last_in;

   assign req_ready = (state_ff == S_IDLE) && sts.clear_done;
   assign rsp_valid = (state_ff == S_RSP);

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      ctl = '0;
      unique case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            ctl.load = 1'b1;
            state_in = S_DISP;
         end
         S_DISP: begin
            ctl.rsp_load = 1'b1;
            ctl.rsp_err = 1'b1;
            state_in = S_RSP;
            unique case (mode_ff)
               MODE_ALLOC: begin
                  ctl.rsp_err = !sts.alloc_ok;
                  ctl.rsp_alloc = sts.alloc_ok;
               end
               MODE_OPEN: if (sts.sid_ok) begin
                  ctl.set_size = 1'b1;
                  ctl.rsp_err = 1'b0;
               end
               MODE_MAP: if (sts.sid_ok) begin
                  ctl.rsp_load = 1'b0;
                  ctl.clr_step = 1'b1;
                  state_in = S_RUNRD;
               end
               MODE_LOOKUP, MODE_UNMAP: begin
                  ctl.rsp_load = 1'b0;
                  ctl.clr_step = 1'b1;
                  ctl.scan = 1'b1;
                  state_in = S_SCRD;
               end
               MODE_FREE: if (sts.sid_ok) begin
                  ctl.rsp_load = 1'b0;
                  ctl.clr_step = 1'b1;
                  state_in = S_FREE;
               end
               default: ;
            endcase
         end
         S_RUNRD: state_in = S_RUNCK;   // read latency
         S_RUNCK: begin
            if (!sts.run_end && sts.mem_vld) begin
               ctl.step = 1'b1;
               state_in = S_RUNRD;
            end else if (sts.fit_ok) begin
               ctl.set_mapped = 1'b1;
               state_in = S_MAPWR;
            end else begin
               ctl.rsp_load = 1'b1;
               ctl.rsp_err = 1'b1;
               state_in = S_RSP;
            end
         end
         S_MAPWR: if (sts.map_done) begin
            ctl.rsp_load = 1'b1;
            state_in = S_RSP;
         end else begin
            ctl.wr_valid = 1'b1;
            ctl.wr_bit = 1'b1;
            ctl.step = 1'b1;
         end
         S_SCRD: begin
            last_in = sts.scan_end;
            ctl.step = !sts.scan_end;
            ctl.scan = 1'b1;
            state_in = S_SCCK;
         end
         S_SCCK: begin
            if (sts.mem_hit && hit_mapped) begin
               ctl.rsp_load = 1'b1;
               ctl.rsp_hit = 1'b1;
               // unmap: cursor has moved on, so clear the slot at the read address
               if (mode_ff == MODE_UNMAP) begin
                  ctl.wr_valid = 1'b1;
                  ctl.wr_hit = 1'b1;
               end
               state_in = S_RSP;
            end else if (last_ff) begin
               ctl.rsp_load = 1'b1;
               ctl.rsp_err = 1'b1;
               state_in = S_RSP;
            end else begin
               last_in = sts.scan_end;
               ctl.step = !sts.scan_end;
               ctl.scan = 1'b1;
            end
         end
         S_FREE: begin
            ctl.wr_valid = 1'b1;
            ctl.step = 1'b1;
            if (sts.store_end) begin
               ctl.clr_store = 1'b1;
               ctl.rsp_load = 1'b1;
               state_in = S_RSP;
            end
         end
         S_RSP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
      end
      if (ctl.load) mode_ff <= req_mode;
   end
endmodule
`default_nettype wire

[hdl/backing_store_page_map.sv]
// Per request word: allocate, open and the unused modes answer from dispatch; map
// walks the leading filled slots, then writes one slot per page; lookup/unmap pass
// over up to NUM_STORES * PAGES_PER_STORE slots; free clears the whole store.
// One request at a time: the next can be accepted in the cycle after the result.
// Reset: synchronous; after reset a clearing pass writes all NUM_STORES *
// PAGES_PER_STORE slots of slot memory before req_ready rises.
`default_nettype none
module backing_store_page_map
   import bspm_pkg::*;
#(
   parameter int NUM_STORES = 8,
   parameter int PAGES_PER_STORE = 256,
   parameter int PID_BITS = 6,
   parameter int VPAGE_BITS = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [5:0]  req_process_id,
   input  wire logic [19:0] req_virtual_page,
   input  wire logic [2:0]  req_store_id,
   input  wire logic [8:0]  req_page_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_status,
   output logic [2:0]       rsp_store_index,
   output logic [7:0]       rsp_page_index
);
   ctl_type ctl, ctl_dp;
   sts_type sts;
   logic    hit_mapped;

   // unmap: on hit, clear that slot in the check cycle by writing the read address
   assign ctl_dp = ctl;

   bspm_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .req_mode,
      .rsp_valid, .rsp_ready, .hit_mapped, .sts, .ctl
   );

   bspm_datapath #(
      .NUM_STORES(NUM_STORES), .PAGES_PER_STORE(PAGES_PER_STORE),
      .PID_BITS(PID_BITS), .VPAGE_BITS(VPAGE_BITS)
   ) u_dp (
      .clock, .reset, .ctl(ctl_dp), .sts, .hit_mapped,
      .req_process_id, .req_virtual_page, .req_store_id, .req_page_count,
      .rsp_status, .rsp_store_index, .rsp_page_index
   );
endmodule
`default_nettype wire

[hdl/bspm_checker.sv]
// Port-level checker for the backing store page map.
`default_nettype none
module bspm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_status,
   input wire logic [2:0] rsp_store_index,
   input wire logic [7:0] rsp_page_index
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_store_index))
      else $error("result dropped");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_page_index == 8'd0)
      else $error("error result with slot index");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result after reset");
endmodule

bind backing_store_page_map bspm_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_store_index, .rsp_page_index
);
`default_nettype wire

[tb/tb_backing_store_page_map.sv]
// Testbench for the backing store page map: directed table, then random words vs. predictor.
`timescale 1ns / 1ps
module tb_backing_store_page_map;
   import bspm_pkg::*;

   localparam int STORES    = 8;
   localparam int SLOTS     = 256;
   localparam int RAND_WORDS = 270;
   localparam int IDLE_LIMIT = 40000;
   localparam int HOLD_CYCLES = 3000;
   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;

   typedef struct packed {
      logic       status;
      logic [2:0] store_index;
      logic [7:0] page_index;
   } rsp_word_type;

   typedef struct {
      logic [2:0]  mode;
      logic [5:0]  pid;
      logic [19:0] vpage;
      logic [2:0]  sid;
      logic [8:0]  count;
      bit          typed;
      rsp_word_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_mode = '0;
   logic [5:0] req_process_id = '0;
   logic [19:0] req_virtual_page = '0;
   logic [2:0] req_store_id = '0;
   logic [8:0] req_page_count = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_status;
   logic [2:0] rsp_store_index;
   logic [7:0] rsp_page_index;

   // typed expectation travels with the word
   bit           cur_typed = 1'b0;
   rsp_word_type cur_want = '0;

   backing_store_page_map DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor state
   bit          pm_mapped [STORES];
   int unsigned pm_size [STORES];
   bit          pm_valid [STORES*SLOTS];
   logic [5:0]  pm_owner [STORES*SLOTS];
   logic [19:0] pm_page [STORES*SLOTS];

   rsp_word_type expected_rsp [$];
   int  mismatches = 0;
   int  words_sent = 0;
   bit  no_idle = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;
   int  idle_cycles = 0;

   function automatic bit find_slot(input logic [5:0] pid, input logic [19:0] vp,
                                    output int s_o, output int k_o);
      for (int s = 0; s < STORES; s++) begin
         if (pm_mapped[s]) begin
            for (int k = 0; k < SLOTS; k++) begin
               if (pm_valid[s*SLOTS+k] && pm_owner[s*SLOTS+k] == pid &&
                   pm_page[s*SLOTS+k] == vp) begin
                  s_o = s;
                  k_o = k;
                  return 1'b1;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_word_type page_map_step(input logic [2:0] mode,
         input logic [5:0] pid, input logic [19:0] vp, input logic [2:0] sid,
         input logic [8:0] cnt);
      rsp_word_type r;
      int s_f, k_f, run;
      r = '{status: 1'b1, store_index: '0, page_index: '0};
      s_f = 0;
      k_f = 0;
      case (mode)
         MODE_ALLOC: begin
            for (int s = STORES - 1; s >= 0; s--) begin
               if (!pm_mapped[s]) begin
                  r.status = 1'b0;
                  r.store_index = s[2:0];
               end
            end
         end
         MODE_OPEN: begin
            pm_size[sid] = (cnt > SLOTS) ? SLOTS : cnt;
            r.status = 1'b0;
         end
         MODE_MAP: begin
            run = 0;
            while (run < pm_size[sid] && pm_valid[sid*SLOTS+run]) run++;
            if (run + cnt <= pm_size[sid]) begin
               pm_mapped[sid] = 1'b1;
               for (int k = 0; k < cnt; k++) begin
                  pm_valid[sid*SLOTS+run+k] = 1'b1;
                  pm_owner[sid*SLOTS+run+k] = pid;
                  pm_page[sid*SLOTS+run+k] = vp + 20'(k);
               end
               r.status = 1'b0;
            end
         end
         MODE_LOOKUP, MODE_UNMAP: begin
            if (find_slot(pid, vp, s_f, k_f)) begin
               r.status = 1'b0;
               r.store_index = s_f[2:0];
               r.page_index = k_f[7:0];
               if (mode == MODE_UNMAP) pm_valid[s_f*SLOTS+k_f] = 1'b0;
            end
         end
         MODE_FREE: begin
            pm_mapped[sid] = 1'b0;
            pm_size[sid] = 0;
            for (int k = 0; k < SLOTS; k++) pm_valid[sid*SLOTS+k] = 1'b0;
            r.status = 1'b0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // monitor: predict on accept, check on result
   always @(posedge clock) begin
      rsp_word_type pred, got, want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pred = page_map_step(req_mode, req_process_id, req_virtual_page,
                                 req_store_id, req_page_count);
            expected_rsp.push_back(cur_typed ? cur_want : pred);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{status: rsp_status, store_index: rsp_store_index,
                    page_index: rsp_page_index};
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word %p", got);
            end else begin
               want = expected_rsp.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected st=%0d si=%0d pi=%0d, got st=%0d si=%0d pi=%0d",
                              want.status, want.store_index, want.page_index,
                              got.status, got.store_index, got.page_index);
               end
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver, with one long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && words_sent >= 120) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= 16);
      end
   end

   task automatic send_word(input logic [2:0] mode, input logic [5:0] pid,
         input logic [19:0] vp, input logic [2:0] sid, input logic [8:0] cnt,
         input bit typed, input rsp_word_type want);
      int gap;
      if (!no_idle && $urandom_range(0, 99) < 16) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_process_id <= pid;
      req_virtual_page <= vp;
      req_store_id <= sid;
      req_page_count <= cnt;
      cur_typed <= typed;
      cur_want <= want;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   plan_row_type plan [21];
   logic [5:0]  map_pid [$];
   logic [19:0] map_vp [$];

   initial begin
      int pick, idx;
      logic [2:0]  m;
      logic [5:0]  p;
      logic [19:0] v;
      logic [8:0]  c;
      plan = '{
         '{MODE_ALLOC,  6'd0,  20'd0,       3'd0, 9'd0,   1, '{1'b0, 3'd0, 8'd0}},
         '{MODE_LOOKUP, 6'd0,  20'd0,       3'd0, 9'd0,   1, '{1'b1, 3'd0, 8'd0}},
         '{MODE_SPARE6, 6'd0,  20'd0,       3'd0, 9'd0,   1, '{1'b1, 3'd0, 8'd0}},
         '{MODE_SPARE7, 6'd63, 20'hFFFFF,   3'd7, 9'd511, 1, '{1'b1, 3'd0, 8'd0}},
         // oversized open saturates
         '{MODE_OPEN,   6'd0,  20'd0,       3'd0, 9'd300, 1, '{1'b0, 3'd0, 8'd0}},
         '{MODE_MAP,    6'd63, 20'hFFFFF,   3'd0, 9'd2,   1, '{1'b0, 3'd0, 8'd0}},
         // second page wrapped to zero
         '{MODE_LOOKUP, 6'd63, 20'd0,       3'd0, 9'd0,   1, '{1'b0, 3'd0, 8'd1}},
         '{MODE_MAP,    6'd1,  20'd0,       3'd0, 9'd256, 1, '{1'b1, 3'd0, 8'd0}},
         '{MODE_ALLOC,  6'd0,  20'd0,       3'd0, 9'd0,   1, '{1'b0, 3'd1, 8'd0}},
         '{MODE_UNMAP,  6'd63, 20'hFFFFF,   3'd0, 9'd0,   1, '{1'b0, 3'd0, 8'd0}},
         '{MODE_LOOKUP, 6'd63, 20'hFFFFF,   3'd0, 9'd0,   1, '{1'b1, 3'd0, 8'd0}},
         // map into the hole left at slot 0
         '{MODE_MAP,    6'd5,  20'h12345,   3'd0, 9'd1,   0, '0},
         '{MODE_LOOKUP, 6'd5,  20'h12345,   3'd0, 9'd0,   0, '0},
         '{MODE_OPEN,   6'd0,  20'd0,       3'd7, 9'd0,   1, '{1'b0, 3'd0, 8'd0}},
         '{MODE_MAP,    6'd0,  20'd0,       3'd7, 9'd0,   1, '{1'b0, 3'd0, 8'd0}},
         '{MODE_OPEN,   6'd0,  20'd0,       3'd7, 9'd256, 1, '{1'b0, 3'd0, 8'd0}},
         '{MODE_MAP,    6'd1,  20'd0,       3'd7, 9'd256, 1, '{1'b0, 3'd0, 8'd0}},
         '{MODE_LOOKUP, 6'd1,  20'd255,     3'd7, 9'd0,   1, '{1'b0, 3'd7, 8'd255}},
         '{MODE_FREE,   6'd0,  20'd0,       3'd0, 9'd0,   1, '{1'b0, 3'd0, 8'd0}},
         '{MODE_FREE,   6'd0,  20'd0,       3'd7, 9'd0,   1, '{1'b0, 3'd0, 8'd0}},
         '{MODE_LOOKUP, 6'd1,  20'd255,     3'd7, 9'd0,   1, '{1'b1, 3'd0, 8'd0}}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_word(plan[i].mode, plan[i].pid, plan[i].vpage, plan[i].sid,
                   plan[i].count, plan[i].typed, plan[i].want);

      for (int n = 0; n < RAND_WORDS; n++) begin
         no_idle = (n >= 60 && n < 110);
         if (n == 180) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_rsp.size() != 0) @(posedge clock);
         end
         p = 6'($urandom);
         v = 20'($urandom);
         c = 9'($urandom_range(0, 6));
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // noise: any mode, any field
            m = 3'($urandom);
            c = 9'($urandom);
         end else if (pick < 25) begin
            m = MODE_OPEN;
            idx = $urandom_range(0, 19);
            c = (idx == 0) ? 9'($urandom_range(256, 511)) : 9'($urandom_range(0, 12));
         end else if (pick < 50) begin
            m = MODE_MAP;
            if ($urandom_range(0, 29) == 0) c = 9'($urandom_range(7, 300));
         end else if (pick < 82) begin
            m = ($urandom_range(0, 2) == 0) ? MODE_UNMAP : MODE_LOOKUP;
            if (map_pid.size() != 0 && $urandom_range(0, 9) < 8) begin
               idx = $urandom_range(0, map_pid.size() - 1);
               p = map_pid[idx];
               v = map_vp[idx] + 20'($urandom_range(0, 3));
            end
         end else if (pick < 90) begin
            m = MODE_FREE;
         end else begin
            m = MODE_ALLOC;
         end
         if (m == MODE_MAP) begin
            map_pid.push_back(p);
            map_vp.push_back(v);
            if (map_pid.size() > 32) begin
               void'(map_pid.pop_front());
               void'(map_vp.pop_front());
            end
         end
         send_word(m, p, v, 3'($urandom), c, 1'b0, '0);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
